/* rtl/lbsfa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lbsfa_pkg: shared constants
// Sizes, status codes, request modes and configuration register indexes for
// the per-link first-fit bit-slot allocator.
// ----------------------------------------------------------------------------
package lbsfa_pkg;

   localparam int NUM_LINKS_DEF   = 4;
   localparam int MAX_ENTRIES_DEF = 16;
   localparam int LINK_BITS_DEF   = 4096;

   localparam int MODE_W   = 2;
   localparam int LINK_W   = 2;
   localparam int CELL_W   = 8;
   localparam int RAT_W    = 2;
   localparam int STATUS_W = 3;
   localparam int START_W  = 12;
   localparam int REMOVED_W = 5;
   localparam int LIU_W    = 3;
   localparam int LEN_W    = 13;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 13;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEL    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // Radio types.
   localparam logic [RAT_W-1:0] RAT_IDLE = 2'd0;
   localparam logic [RAT_W-1:0] RAT_UMTS = 2'd1;
   localparam logic [RAT_W-1:0] RAT_LTE  = 2'd2;
   localparam logic [RAT_W-1:0] RAT_GSM  = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOROOM = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ZERO   = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_LINKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_UMTS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LTE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GSM   = 2'd3;

   localparam logic [LIU_W-1:0] LINKS_RST = 3'd4;
   localparam logic [LEN_W-1:0] UMTS_RST  = 13'd24;
   localparam logic [LEN_W-1:0] LTE_RST   = 13'd402;
   localparam logic [LEN_W-1:0] GSM_RST   = 13'd5;

endpackage : lbsfa_pkg
`default_nettype wire

/* rtl/lbsfa_entry_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lbsfa_entry_ram: entry store
// Synchronous single-port-write, single-read memory of the interval entries,
// one row per link and list position, with a registered read.
// ----------------------------------------------------------------------------
module lbsfa_entry_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 34
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output      logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule : lbsfa_entry_ram
`default_nettype wire

/* rtl/link_bit_slot_first_fit_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// link_bit_slot_first_fit_allocator: per-link first-fit interval allocator
// Keeps a sorted list of bit intervals per link in one memory; adds intervals
// first-fit, deletes by cell id with compaction, and clears all links.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  mode, link, cell_id, rat
// rsp_      out        rsp_valid/rsp_ready  status, start_bit, removed_count
// csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// One transaction at a time. An add walks the list through the memory read
// port, reading and testing each entry, up to the chosen gap, then shifts the
// entries above it up one at a time, each moved entry read and then written,
// and writes the new entry into the gap. A delete walks and compacts in one
// pass. Clear and rejected requests go straight to the response. Reset empties
// every link at once through the per-link counts. A stalled result holds the
// block until taken.
// ----------------------------------------------------------------------------
module link_bit_slot_first_fit_allocator
   import lbsfa_pkg::*;
#(
   parameter int NUM_LINKS   = lbsfa_pkg::NUM_LINKS_DEF,
   parameter int MAX_ENTRIES = lbsfa_pkg::MAX_ENTRIES_DEF,
   parameter int LINK_BITS   = lbsfa_pkg::LINK_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire logic [lbsfa_pkg::MODE_W-1:0]       req_mode,
   input  wire logic [lbsfa_pkg::LINK_W-1:0]       req_link,
   input  wire logic [lbsfa_pkg::CELL_W-1:0]       req_cell_id,
   input  wire logic [lbsfa_pkg::RAT_W-1:0]        req_rat,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      logic [lbsfa_pkg::STATUS_W-1:0]     rsp_status,
   output      logic [lbsfa_pkg::START_W-1:0]      rsp_start_bit,
   output      logic [lbsfa_pkg::REMOVED_W-1:0]    rsp_removed_count,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [lbsfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lbsfa_pkg::CSR_DAT_W-1:0]    csr_data
);

   localparam int LW    = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
   localparam int EW    = $clog2(MAX_ENTRIES);
   localparam int CW    = $clog2(MAX_ENTRIES + 1);
   localparam int PW    = $clog2(LINK_BITS + 1);
   localparam int AW    = LW + EW;
   localparam int DEPTH = NUM_LINKS * (2 ** EW);
   localparam int DW    = CELL_W + 2 * PW;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_SRD   = 8'b0000_0010,
      S_SCHK  = 8'b0000_0100,
      S_MRD   = 8'b0000_1000,
      S_MWR   = 8'b0001_0000,
      S_DRD   = 8'b0010_0000,
      S_DCHK  = 8'b0100_0000,
      S_RSP   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [LIU_W-1:0] links_ff;
   logic [LEN_W-1:0] umts_ff, lte_ff, gsm_ff;
   logic [CW-1:0]    count_ff [NUM_LINKS];

   logic [LW-1:0]     link_ff, link_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic [PW-1:0]     len_ff, len_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     keep_ff, keep_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [PW-1:0]     cur_ff, cur_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [START_W-1:0]   start_ff, start_in;
   logic [REMOVED_W-1:0] removed_ff, removed_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [DW-1:0] wr_data, rd_data;

   logic [CELL_W-1:0] rd_cell;
   logic [PW-1:0]     rd_start, rd_end;
   logic [LEN_W-1:0]  sel_len;
   logic              present;
   logic [LW-1:0]     req_lk;
   logic [CW-1:0]     n_cur;
   logic [PW:0]       fit_end;

   assign rd_cell  = rd_data[DW-1 -: CELL_W];
   assign rd_start = rd_data[2*PW-1 -: PW];
   assign rd_end   = rd_data[PW-1:0];
   assign req_lk   = LW'(req_link);
   assign n_cur    = count_ff[link_ff];
   assign fit_end  = {1'b0, cur_ff} + {1'b0, len_ff};

   // Length by radio type.
   always_comb begin
      case (req_rat)
         RAT_UMTS: sel_len = umts_ff;
         RAT_LTE:  sel_len = lte_ff;
         RAT_GSM:  sel_len = gsm_ff;
         default:  sel_len = '0;
      endcase
   end

   // A link exists below the configured count and below the built-in count.
   assign present = (int'(req_link) < int'(links_ff)) && (int'(req_link) < NUM_LINKS);

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_status = status_ff;
   assign rsp_start_bit = start_ff;
   assign rsp_removed_count = removed_ff;

   lbsfa_entry_ram #(.DEPTH(DEPTH), .AW(AW), .DW(DW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer: search, shift, insert, and delete compaction.
   always_comb begin
      state_in   = state_ff;
      link_in    = link_ff;
      cell_in    = cell_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      keep_in    = keep_ff;
      pos_in     = pos_ff;
      cur_in     = cur_ff;
      status_in  = status_ff;
      start_in   = start_ff;
      removed_in = removed_ff;
      wr_en      = 1'b0;
      wr_addr    = {link_ff, EW'(idx_ff)};
      wr_data    = {cell_ff, cur_ff, fit_end[PW-1:0]};
      rd_addr    = {link_ff, EW'(idx_ff)};
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               link_in    = req_lk;
               cell_in    = req_cell_id;
               len_in     = PW'(sel_len);
               idx_in     = '0;
               keep_in    = '0;
               cur_in     = '0;
               status_in  = ST_OK;
               start_in   = '0;
               removed_in = '0;
               state_in   = S_RSP;
               case (req_mode)
                  MODE_ADD: begin
                     if (!present) status_in = ST_ABSENT;
                     else if (sel_len == '0) status_in = ST_ZERO;
                     else if (count_ff[req_lk] >= CW'(MAX_ENTRIES)) status_in = ST_FULL;
                     else if (int'(sel_len) > LINK_BITS) status_in = ST_NOROOM;
                     else state_in = S_SRD;
                  end
                  MODE_DEL: begin
                     if (!present) status_in = ST_ABSENT;
                     else state_in = S_DRD;
                  end
                  default: ;
               endcase
            end
         end
         // Issue the read of the next entry, or settle at the list end.
         S_SRD: begin
            if (idx_ff == n_cur) begin
               if (fit_end > (PW+1)'(LINK_BITS)) begin
                  status_in = ST_NOROOM;
                  state_in  = S_RSP;
               end else begin
                  pos_in   = idx_ff;
                  idx_in   = n_cur;
                  state_in = S_MRD;
               end
            end else begin
               state_in = S_SCHK;
            end
         end
         // Gap test against the entry just read.
         S_SCHK: begin
            if (rd_start >= cur_ff && (rd_start - cur_ff) >= len_ff) begin
               pos_in   = idx_ff;
               idx_in   = n_cur;
               state_in = S_MRD;
            end else begin
               if (rd_end > cur_ff) cur_in = rd_end;
               idx_in   = idx_ff + 1'b1;
               state_in = S_SRD;
            end
         end
         // Shift the tail up by one, from the top down, then insert.
         S_MRD: begin
            if (idx_ff == pos_ff) begin
               wr_en     = 1'b1;
               start_in  = START_W'(cur_ff);
               state_in  = S_RSP;
            end else begin
               rd_addr  = {link_ff, EW'(idx_ff - 1'b1)};
               state_in = S_MWR;
            end
         end
         S_MWR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            idx_in   = idx_ff - 1'b1;
            state_in = S_MRD;
         end
         // Delete: read each entry, write back the survivors packed.
         S_DRD: begin
            if (idx_ff == n_cur) begin
               removed_in = REMOVED_W'(idx_ff - keep_ff);
               state_in   = S_RSP;
            end else begin
               state_in = S_DCHK;
            end
         end
         S_DCHK: begin
            if (rd_cell != cell_ff) begin
               wr_en   = 1'b1;
               wr_addr = {link_ff, EW'(keep_ff)};
               wr_data = rd_data;
               keep_in = keep_ff + 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_DRD;
         end
         S_RSP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers, counts and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         links_ff <= LINKS_RST;
         umts_ff  <= UMTS_RST;
         lte_ff   <= LTE_RST;
         gsm_ff   <= GSM_RST;
         for (int i = 0; i < NUM_LINKS; i++) count_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_LINKS: links_ff <= csr_data[LIU_W-1:0];
               REG_UMTS:  umts_ff  <= csr_data;
               REG_LTE:   lte_ff   <= csr_data;
               REG_GSM:   gsm_ff   <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == S_IDLE && req_valid && req_mode == MODE_CLEAR) begin
            for (int i = 0; i < NUM_LINKS; i++) count_ff[i] <= '0;
         end
         if (state_ff == S_MRD && idx_ff == pos_ff) begin
            count_ff[link_ff] <= n_cur + 1'b1;
         end
         if (state_ff == S_DRD && idx_ff == n_cur) begin
            count_ff[link_ff] <= keep_ff;
         end
      end
   end

   // Working registers of the current transaction.
   always_ff @(posedge clock) begin
      link_ff    <= link_in;
      cell_ff    <= cell_in;
      len_ff     <= len_in;
      idx_ff     <= idx_in;
      keep_ff    <= keep_in;
      pos_ff     <= pos_in;
      cur_ff     <= cur_in;
      status_ff  <= status_in;
      start_ff   <= start_in;
      removed_ff <= removed_in;
   end

endmodule : link_bit_slot_first_fit_allocator
`default_nettype wire
